>>> rtl/core/sorted_unique_set_insert_top_assert.svh
// Assertion macros for the sorted unique set insert block.
// Used by the checker; expects clk_i and rst_ni in the calling scope.
`ifndef SORTED_UNIQUE_SET_INSERT_TOP_ASSERT_SVH
`define SORTED_UNIQUE_SET_INSERT_TOP_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define SUS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SUS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/core/sus_pkg.sv
// Shared types, constants and helpers of the sorted unique set insert block.
// No dependencies; imported by every module of the block.
package sus_pkg;

  localparam int CAPACITY = 64;
  localparam int VAL_W    = 31;
  localparam int POS_W    = 6;
  localparam int CNTF_W   = 7;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_PRESENT  = 2'd1,
    ST_DROPPED  = 2'd2
  } status_e;

  // Data handed from one cell to the next one up
  typedef struct packed {
    logic             lt;
    logic [VAL_W-1:0] entry;
  } cell_link_t;

  // Per-cell search flags
  typedef struct packed {
    logic bnd;
    logic hit;
  } cell_flag_t;

  // Clamp a slot number to the position field
  function automatic logic [POS_W-1:0] sat_pos(input logic [CNT_W-1:0] v);
    logic [POS_W-1:0] r;
    if (32'(v) > ((32'd1 << POS_W) - 32'd1)) begin
      r = '1;
    end else begin
      r = POS_W'(v);
    end
    return r;
  endfunction

  // Clamp an entry count to the count field
  function automatic logic [CNTF_W-1:0] sat_cnt(input logic [CNT_W-1:0] v);
    logic [CNTF_W-1:0] r;
    if (32'(v) > ((32'd1 << CNTF_W) - 32'd1)) begin
      r = '1;
    end else begin
      r = CNTF_W'(v);
    end
    return r;
  endfunction

endpackage

>>> rtl/core/sus_cell.sv
// One compare-and-shift cell of the sorted set chain.
// Depends on sus_pkg for the link and flag types.
module sus_cell
  import sus_pkg::*;
(
  input  logic             clk_i,
  input  logic             ins_en_i,
  input  logic             occ_i,
  input  logic [VAL_W-1:0] x_i,
  input  cell_link_t       prev_i,
  output cell_link_t       link_o,
  output cell_flag_t       flag_o
);

  logic [VAL_W-1:0] entry_q;
  logic             lt;

  // Compare the held entry against the incoming value
  assign lt           = occ_i && (entry_q < x_i);
  assign link_o.lt    = lt;
  assign link_o.entry = entry_q;

  // First slot not below the value; a hit there means a duplicate
  assign flag_o.bnd = !lt && prev_i.lt;
  assign flag_o.hit = flag_o.bnd && occ_i && (entry_q == x_i);

  // Take the new value at the boundary, shift up above it
  always_ff @(posedge clk_i) begin
    if (ins_en_i) begin
      if (flag_o.bnd) begin
        entry_q <= x_i;
      end else if (!prev_i.lt) begin
        entry_q <= prev_i.entry;
      end
    end
  end

endmodule

>>> rtl/core/sus_enc.sv
// Encodes the one-hot boundary flags of the cell chain into a slot number.
// Depends on sus_pkg for the capacity and widths.
module sus_enc
  import sus_pkg::*;
(
  input  logic [CAPACITY-1:0] bnd_i,
  output logic [CNT_W-1:0]    pos_o
);

  // OR together the indices of set flags; no flag means past the last slot
  always_comb begin
    pos_o = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (bnd_i[i]) begin
        pos_o = pos_o | CNT_W'(i);
      end
    end
    if (!(|bnd_i)) begin
      pos_o = CNT_FULL;
    end
  end

endmodule

>>> rtl/core/sorted_unique_set_insert_top.sv
// Sorted unique set insert: keeps a strictly increasing set of up to CAPACITY
// 31-bit indices and inserts one value per accepted input item.
//
// Input channel: in_valid_i / in_ready_o carry value_i and batch_last_i.
// Output channel: out_valid_o / out_ready_i carry status_o (inserted,
// already present, or dropped because the set is full), position_o (sorted
// slot, clamped to 63), count_o (entries held after the item) and
// batch_done_o (echo of batch_last_i).
//
// The result of an accepted item is registered and shown from the cycle
// after it is accepted. Every cell of the chain compares its entry with the
// value in the same cycle and shifts toward its upper neighbor, so one item
// is taken per cycle unless a stalled receiver holds the output register.
// A stalled receiver holds the result register; the input is still taken in
// the cycle the pending result leaves, and not before.
// Reset empties the set (count zero) and clears the output valid; entry
// contents are not cleared, as slots at or above the count are never read.
module sorted_unique_set_insert_top
  import sus_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [VAL_W-1:0]  value_i,
  input  logic              batch_last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [POS_W-1:0]  position_o,
  output logic [CNTF_W-1:0] count_o,
  output logic              batch_done_o
);

  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                out_valid_q;
  status_e             status_q, status_d;
  logic [POS_W-1:0]    position_q;
  logic [CNTF_W-1:0]   count_q;
  logic                batch_done_q;

  cell_link_t          link [CAPACITY+1];
  cell_flag_t          flag [CAPACITY];
  logic [CAPACITY-1:0] bnd;
  logic [CAPACITY-1:0] hit;
  logic [CNT_W-1:0]    pos_full;
  logic                accept;
  logic                dup;
  logic                full;
  logic                ins_en;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Chain bottom: treat the slot below zero as smaller than any value
  assign link[0].lt    = 1'b1;
  assign link[0].entry = value_i;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sus_cell u_cell (
      .clk_i    (clk_i),
      .ins_en_i (ins_en),
      .occ_i    (CNT_W'(i) < cnt_q),
      .x_i      (value_i),
      .prev_i   (link[i]),
      .link_o   (link[i+1]),
      .flag_o   (flag[i])
    );
    assign bnd[i] = flag[i].bnd;
    assign hit[i] = flag[i].hit;
  end

  sus_enc u_enc (
    .bnd_i (bnd),
    .pos_o (pos_full)
  );

  // Decide the outcome of this item
  assign dup    = |hit;
  assign full   = (cnt_q == CNT_FULL);
  assign ins_en = accept && !dup && !full;

  always_comb begin
    cnt_d = cnt_q;
    if (dup) begin
      status_d = ST_PRESENT;
    end else if (full) begin
      status_d = ST_DROPPED;
    end else begin
      status_d = ST_INSERTED;
      cnt_d    = cnt_q + CNT_W'(1);
    end
  end

  // Advance the entry count and the output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result payload until the next accepted item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q     <= status_d;
      position_q   <= sat_pos(pos_full);
      count_q      <= sat_cnt(cnt_d);
      batch_done_q <= batch_last_i;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign position_o   = position_q;
  assign count_o      = count_q;
  assign batch_done_o = batch_done_q;

endmodule

>>> rtl/core/sus_checker.sv
// Port-level checker for the sorted unique set insert block, with its bind.
// Depends on sus_pkg and the assertion macros in the block's header.
`include "sorted_unique_set_insert_top_assert.svh"

module sus_checker
  import sus_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [1:0]        status_o,
  input logic [POS_W-1:0]  position_o,
  input logic [CNTF_W-1:0] count_o,
  input logic              batch_done_o
);

  // A stalled result stays put
  `SUS_ASSERT(a_out_hold,
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(position_o) && $stable(count_o) && $stable(batch_done_o),
    "result changed while stalled")

  // With no pending result the block takes input
  `SUS_ASSERT_ALWAYS(a_ready_idle, !out_valid_o |-> in_ready_o,
    "not ready while output empty")

  // Count never exceeds the capacity
  `SUS_ASSERT(a_count_cap, out_valid_o |-> 32'(count_o) <= CAPACITY,
    "count above capacity")

  // A dropped value only happens on a full set
  `SUS_ASSERT(a_drop_full,
    out_valid_o && status_o == ST_DROPPED |-> 32'(count_o) == CAPACITY,
    "drop on a set that is not full")

  // An inserted value lies inside the set
  `SUS_ASSERT(a_ins_pos,
    out_valid_o && status_o == ST_INSERTED |-> 32'(position_o) < 32'(count_o),
    "insert slot outside the set")

endmodule

bind sorted_unique_set_insert_top sus_checker u_sus_checker (.*);
